/* rtl/gnf_pkg.sv */
// gnf_pkg: shared types, codes and defaults of the fractal gradient noise unit
// depends on nothing; used by the top level, gnf_front and gnf_core

package gnf_pkg;

  localparam int TABLE_SIZE_DEF  = 256;
  localparam int MAX_OCT_DEF     = 8;
  localparam int Q_DEPTH         = 2;

  localparam logic [1:0] REQ_LOAD_PERM = 2'd0;
  localparam logic [1:0] REQ_LOAD_GRAD = 2'd1;
  localparam logic [1:0] REQ_SAMPLE    = 2'd2;

  localparam logic [2:0] CFG_BASE_AMP  = 3'd0;
  localparam logic [2:0] CFG_BASE_FREQ = 3'd1;
  localparam logic [2:0] CFG_OCT_COUNT = 3'd2;
  localparam logic [2:0] CFG_PERSIST   = 3'd3;
  localparam logic [2:0] CFG_LACUNAR   = 3'd4;

  localparam logic [15:0] RST_BASE_AMP  = 16'd4096;
  localparam logic [15:0] RST_BASE_FREQ = 16'd256;
  localparam logic [3:0]  RST_OCT_COUNT = 4'd1;
  localparam logic [15:0] RST_PERSIST   = 16'd32768;
  localparam logic [15:0] RST_LACUNAR   = 16'd8192;

  localparam logic signed [31:0] NOISE_MAX = 32'sd16384;
  localparam logic signed [31:0] NOISE_MIN = -32'sd16384;

  typedef struct packed {
    logic [15:0] base_amp;
    logic [15:0] base_freq;
    logic [3:0]  oct_count;
    logic [15:0] persist;
    logic [15:0] lacunar;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         idx;
    logic [7:0]         perm;
    logic [31:0]        grad;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } item_t;

endpackage

/* rtl/gradient_noise_2d_fractal_unit.sv */
// gradient_noise_2d_fractal_unit: top level, configuration registers and the two halves
// depends on gnf_pkg, gnf_front and gnf_core
// a sample runs in the core after it leaves the queue; per octave it passes through
//   a scale step, table lookups on the one read port of each table, dot products and a blend
// the core takes no new request until the current sample is done; table loads are written when popped
// reset clears control and loads the configuration defaults; tables hold garbage until loaded

module gradient_noise_2d_fractal_unit #(
  parameter int TABLE_SIZE  = gnf_pkg::TABLE_SIZE_DEF,
  parameter int MAX_OCTAVES = gnf_pkg::MAX_OCT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_req_type,
  input  logic [7:0]         in_table_index,
  input  logic [7:0]         in_perm_value,
  input  logic signed [15:0] in_grad_x,
  input  logic signed [15:0] in_grad_y,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [15:0] out_noise_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  gnf_pkg::cfg_t  cfg_r;
  gnf_pkg::item_t in_item, q_item;
  logic           q_valid, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_amp  <= gnf_pkg::RST_BASE_AMP;
      cfg_r.base_freq <= gnf_pkg::RST_BASE_FREQ;
      cfg_r.oct_count <= gnf_pkg::RST_OCT_COUNT;
      cfg_r.persist   <= gnf_pkg::RST_PERSIST;
      cfg_r.lacunar   <= gnf_pkg::RST_LACUNAR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gnf_pkg::CFG_BASE_AMP:  cfg_r.base_amp  <= cfg_data;
        gnf_pkg::CFG_BASE_FREQ: cfg_r.base_freq <= cfg_data;
        gnf_pkg::CFG_OCT_COUNT: cfg_r.oct_count <= cfg_data[3:0];
        gnf_pkg::CFG_PERSIST:   cfg_r.persist   <= cfg_data;
        gnf_pkg::CFG_LACUNAR:   cfg_r.lacunar   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_item.kind = in_req_type;
  assign in_item.idx  = in_table_index;
  assign in_item.perm = in_perm_value;
  assign in_item.grad = {in_grad_y, in_grad_x};
  assign in_item.x    = in_coord_x;
  assign in_item.y    = in_coord_y;

  gnf_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  gnf_core #(.TABLE_SIZE(TABLE_SIZE), .MAX_OCTAVES(MAX_OCTAVES)) u_core (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_valid(q_valid), .q_item(q_item),
    .q_pop(q_pop), .out_empty(out_empty), .out_pop(out_pop),
    .out_noise_value(out_noise_value)
  );

endmodule

/* rtl/gnf_ram.sv */
// gnf_ram: generic single write, single read ram with registered read data
// depends on nothing

module gnf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* rtl/gnf_front.sv */
// gnf_front: accepts requests, drops unknown and out-of-range ones, queues the rest
// depends on gnf_pkg

module gnf_front #(
  parameter int TABLE_SIZE = gnf_pkg::TABLE_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  gnf_pkg::item_t     in_item,
  output logic               q_valid,
  input  logic               q_pop,
  output gnf_pkg::item_t     q_item
);

  localparam int QAW = $clog2(gnf_pkg::Q_DEPTH);

  gnf_pkg::item_t mem_r [gnf_pkg::Q_DEPTH];
  logic [QAW-1:0] wptr_r, rptr_r;
  logic [QAW:0]   count_r;
  logic           keep;
  logic           wr_en, rd_en;

  always_comb begin
    keep = 1'b0;
    unique case (in_item.kind) inside
      gnf_pkg::REQ_LOAD_PERM, gnf_pkg::REQ_LOAD_GRAD: begin
        keep = {24'd0, in_item.idx} < 32'(TABLE_SIZE);
      end
      gnf_pkg::REQ_SAMPLE: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign in_full = count_r == (QAW+1)'(gnf_pkg::Q_DEPTH);
  assign q_valid = count_r != '0;
  assign q_item  = mem_r[rptr_r];
  assign wr_en   = in_push && !in_full && keep;
  assign rd_en   = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (wr_en) wptr_r <= wptr_r + 1'b1;
      if (rd_en) rptr_r <= rptr_r + 1'b1;
      case ({wr_en, rd_en})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/gnf_core.sv */
// gnf_core: executes queued requests; table writes and the octave sequencer
// depends on gnf_pkg and gnf_ram

module gnf_core #(
  parameter int TABLE_SIZE  = gnf_pkg::TABLE_SIZE_DEF,
  parameter int MAX_OCTAVES = gnf_pkg::MAX_OCT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gnf_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  gnf_pkg::item_t     q_item,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [15:0] out_noise_value
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int OW = $clog2(MAX_OCTAVES + 1);
  localparam int CW = (OW > 4) ? OW : 4;
  localparam int DW = 22;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_DOT   = 3'd3;
  localparam logic [2:0] ST_BLEND = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]            state_r;
  logic [2:0]            cnt_r;
  logic [OW-1:0]         oct_r, noct_r, noct_sel;
  logic signed [31:0]    x_r, y_r, sum_r;
  logic [15:0]           amp_r, freq_r;
  logic signed [48:0]    px_r, py_r;
  logic [15:0]           t2x_r, t2y_r, u_r, v_r;
  logic [7:0]            h0_r, h1_r;
  logic [31:0]           grad_r [4];
  logic signed [33:0]    prx_r, pry_r;
  logic signed [DW-1:0]  dot_r [4];
  logic signed [39:0]    pa_r, pb_r;
  logic signed [DW-1:0]  a_r, b_r, n_r;
  logic signed [38:0]    tp_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic signed [15:0]    out_data_r;

  logic                  perm_we, grad_we;
  logic [AW-1:0]         perm_raddr, grad_raddr, tab_waddr;
  logic [7:0]            perm_rdata;
  logic [31:0]           grad_rdata;
  logic [AW-1:0]         x0, x1, y0, y1;
  logic [15:0]           tx, ty;
  logic [31:0]           gsel;
  logic signed [17:0]    ox, oy;
  logic signed [34:0]    dot_sum;
  logic signed [DW:0]    op_a;
  logic [15:0]           op_s;
  logic signed [39:0]    mul_a;
  logic signed [DW:0]    diff_b;
  logic [31:0]           amp_prod, freq_prod;
  logic [15:0]           freq_sat;
  logic signed [31:0]    clamp;
  logic                  out_free;
  logic [1:0]            dix;

  gnf_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_perm (
    .clk(clk), .we(perm_we), .waddr(tab_waddr), .wdata(q_item.perm),
    .raddr(perm_raddr), .rdata(perm_rdata)
  );

  gnf_ram #(.WIDTH(32), .DEPTH(TABLE_SIZE)) u_grad (
    .clk(clk), .we(grad_we), .waddr(tab_waddr), .wdata(q_item.grad),
    .raddr(grad_raddr), .rdata(grad_rdata)
  );

  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign tab_waddr = AW'(q_item.idx);
  assign perm_we   = q_pop && (q_item.kind == gnf_pkg::REQ_LOAD_PERM);
  assign grad_we   = q_pop && (q_item.kind == gnf_pkg::REQ_LOAD_GRAD);

  assign noct_sel = (CW'(cfg.oct_count) > CW'(MAX_OCTAVES)) ? OW'(MAX_OCTAVES)
                                                              : OW'(cfg.oct_count);

  assign x0 = px_r[24 +: AW];
  assign y0 = py_r[24 +: AW];
  assign x1 = x0 + 1'b1;
  assign y1 = y0 + 1'b1;
  assign tx = px_r[23:8];
  assign ty = py_r[23:8];

  always_comb begin
    case (cnt_r)
      3'd0:    perm_raddr = x0;
      3'd1:    perm_raddr = x1;
      3'd2:    perm_raddr = AW'(h0_r) + y0;
      3'd3:    perm_raddr = AW'(h0_r) + y1;
      3'd4:    perm_raddr = AW'(h1_r) + y0;
      3'd5:    perm_raddr = AW'(h1_r) + y1;
      default: perm_raddr = x0;
    endcase
  end
  assign grad_raddr = AW'(perm_rdata);

  assign gsel    = grad_r[cnt_r[1:0]];
  assign ox      = cnt_r[1] ? $signed({2'b11, tx}) : $signed({2'b00, tx});
  assign oy      = cnt_r[0] ? $signed({2'b11, ty}) : $signed({2'b00, ty});
  assign dot_sum = 35'(prx_r) + 35'(pry_r);
  assign dix     = 2'(cnt_r - 3'd1);

  always_comb begin
    if (cnt_r == 3'd0) begin
      op_a = (DW+1)'(dot_r[2]) - (DW+1)'(dot_r[0]);
      op_s = u_r;
    end else begin
      op_a = (DW+1)'(b_r) - (DW+1)'(a_r);
      op_s = v_r;
    end
  end
  assign mul_a  = op_a * $signed({1'b0, op_s});
  assign diff_b = (DW+1)'(dot_r[3]) - (DW+1)'(dot_r[1]);

  assign amp_prod  = amp_r * cfg.persist;
  assign freq_prod = freq_r * cfg.lacunar;
  assign freq_sat  = (freq_prod[31:28] != 4'd0) ? 16'hFFFF : freq_prod[27:12];

  always_comb begin
    if (sum_r > gnf_pkg::NOISE_MAX)      clamp = gnf_pkg::NOISE_MAX;
    else if (sum_r < gnf_pkg::NOISE_MIN) clamp = gnf_pkg::NOISE_MIN;
    else                                 clamp = sum_r;
  end

  assign out_free        = !out_valid_r || out_pop;
  assign out_empty       = !out_valid_r;
  assign out_noise_value = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_pop;
    if (state_r == ST_DONE && out_free) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        x_r    <= q_item.x;
        y_r    <= q_item.y;
        amp_r  <= cfg.base_amp;
        freq_r <= cfg.base_freq;
        noct_r <= noct_sel;
        sum_r  <= '0;
      end
      ST_MUL: begin
        px_r <= x_r * $signed({1'b0, freq_r});
        py_r <= y_r * $signed({1'b0, freq_r});
      end
      ST_LOOK: begin
        t2x_r <= 16'((32'(tx) * 32'(tx)) >> 16);
        t2y_r <= 16'((32'(ty) * 32'(ty)) >> 16);
        u_r   <= 16'((34'(t2x_r) * (34'd196608 - 34'({tx, 1'b0}))) >> 16);
        v_r   <= 16'((34'(t2y_r) * (34'd196608 - 34'({ty, 1'b0}))) >> 16);
        if (cnt_r == 3'd1) h0_r <= perm_rdata;
        if (cnt_r == 3'd2) h1_r <= perm_rdata;
        if (cnt_r >= 3'd4) grad_r[cnt_r[1:0]] <= grad_rdata;
      end
      ST_DOT: begin
        prx_r <= $signed(gsel[15:0]) * ox;
        pry_r <= $signed(gsel[31:16]) * oy;
        if (cnt_r != 3'd0) dot_r[dix] <= DW'(dot_sum >>> 15);
      end
      ST_BLEND: begin
        case (cnt_r)
          3'd0: begin
            pa_r <= mul_a;
            pb_r <= diff_b * $signed({1'b0, u_r});
          end
          3'd1: begin
            a_r <= dot_r[0] + DW'(pa_r >>> 16);
            b_r <= dot_r[1] + DW'(pb_r >>> 16);
          end
          3'd2: pa_r <= mul_a;
          3'd3: n_r  <= a_r + DW'(pa_r >>> 16);
          3'd4: tp_r <= $signed({1'b0, amp_r}) * n_r;
          default: begin
            sum_r  <= sum_r + 32'(tp_r >>> 14);
            amp_r  <= amp_prod[31:16];
            freq_r <= freq_sat;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      oct_r       <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          oct_r <= '0;
          if (q_valid && q_item.kind == gnf_pkg::REQ_SAMPLE) begin
            state_r <= (noct_sel == '0) ? ST_DONE : ST_MUL;
          end
        end
        ST_MUL: begin
          state_r <= ST_LOOK;
          cnt_r   <= '0;
        end
        ST_LOOK: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            state_r <= ST_DOT;
            cnt_r   <= '0;
          end
        end
        ST_DOT: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd4) begin
            state_r <= ST_BLEND;
            cnt_r   <= '0;
          end
        end
        ST_BLEND: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd5) begin
            cnt_r <= '0;
            oct_r <= oct_r + 1'b1;
            state_r <= (oct_r + 1'b1 == noct_r) ? ST_DONE : ST_MUL;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_data_r  <= clamp[15:0];
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
